@@ src/scp_pkg.sv @@
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants for the serial set-command parser.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 5;
  localparam int unsigned AccW     = 16;
  localparam int unsigned ValW     = 11;
  localparam int unsigned NumField = 4;

  localparam int unsigned MaxLenDefault = 25;

  localparam logic [ByteW-1:0]  CharBar   = 8'd124;
  localparam logic [ByteW-1:0]  CharSemi  = 8'd59;
  localparam logic [ByteW-1:0]  CharA     = 8'd97;
  localparam logic [ByteW-1:0]  CharNul   = 8'd0;
  localparam logic [AccW-1:0]   DigitBase = 16'd48;
  localparam logic [AccW-1:0]   ValLimit  = 16'd1024;
  localparam logic [CountW-1:0] FieldSat  = 5'd31;
  localparam logic [CountW-1:0] FieldLast = 5'd4;

  // Parse state of the frame in progress.
  typedef struct packed {
    logic [ByteW-1:0]                 action;
    logic [CountW-1:0]                fcount;
    logic [NumField-1:0][AccW-1:0]    acc;
    logic                             nul;
  } frame_t;

  typedef struct packed {
    logic                             ok;
    logic [NumField-1:0][ValW-1:0]    val;
  } result_t;

endpackage

@@ src/scp_frame.sv @@
// ----------------------------------------------------------------------------
// scp_frame
// Frame state registers and the per-byte parse update; flags frame close.
// ----------------------------------------------------------------------------
module scp_frame #(
  parameter int unsigned MaxLen = scp_pkg::MaxLenDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       beat_i,
  input  logic [scp_pkg::ByteW-1:0]  byte_i,
  output logic                       close_o,
  output scp_pkg::frame_t            close_state_o
);
  import scp_pkg::*;

  frame_t            st_q, st_d;
  logic [CountW-1:0] cnt_q, cnt_inc;
  logic [CountW-1:0] fc_m1;
  logic [1:0]        idx;
  logic [AccW-1:0]   sel_acc;
  logic              is_bar;

  assign fc_m1   = st_q.fcount - 5'd1;
  assign idx     = fc_m1[1:0];
  assign sel_acc = st_q.acc[idx];

  always_comb begin
    st_d = st_q;
    if (!st_q.nul) begin
      if (byte_i == CharNul) begin
        st_d.nul = 1'b1;
      end else if (byte_i == CharSemi) begin
        if (st_q.fcount != FieldSat) st_d.fcount = st_q.fcount + 5'd1;
      end else if (st_q.fcount == '0) begin
        st_d.action = byte_i;
      end else if (st_q.fcount <= FieldLast) begin
        // acc * 10 plus the sign-extended byte, less the ASCII zero, mod 2^16.
        st_d.acc[idx] = (sel_acc << 3) + (sel_acc << 1)
                      + {{(AccW-ByteW){byte_i[ByteW-1]}}, byte_i} - DigitBase;
      end
    end
  end

  assign is_bar  = (byte_i == CharBar);
  assign cnt_inc = cnt_q + 5'd1;
  assign close_o = is_bar || (cnt_inc >= CountW'(MaxLen));
  // A closing bar is not part of the frame; a full frame includes this byte.
  assign close_state_o = is_bar ? st_q : st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      cnt_q <= '0;
    end else if (beat_i) begin
      if (close_o) begin
        st_q  <= '0;
        cnt_q <= '0;
      end else begin
        st_q  <= st_d;
        cnt_q <= cnt_inc;
      end
    end
  end

endmodule

@@ src/scp_check.sv @@
// ----------------------------------------------------------------------------
// scp_check
// Validates a closed frame and forms the result fields.
// ----------------------------------------------------------------------------
module scp_check (
  input  scp_pkg::frame_t  frame_i,
  output scp_pkg::result_t res_o
);
  import scp_pkg::*;

  logic [NumField-1:0] in_range;
  logic                ok;

  always_comb begin
    for (int k = 0; k < NumField; k++) begin
      // Negative as signed 16-bit, or above the limit, fails.
      in_range[k] = !frame_i.acc[k][AccW-1] && (frame_i.acc[k] <= ValLimit);
    end
  end

  assign ok = (frame_i.action == CharA) && (frame_i.fcount == FieldLast) && (&in_range);

  always_comb begin
    res_o.ok = ok;
    for (int k = 0; k < NumField; k++) begin
      res_o.val[k] = ok ? frame_i.acc[k][ValW-1:0] : '0;
    end
  end

endmodule

@@ src/scp_out_reg.sv @@
// ----------------------------------------------------------------------------
// scp_out_reg
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module scp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  scp_pkg::result_t res_i,
  input  logic             ready_i,
  output logic             valid_o,
  output scp_pkg::result_t res_o
);
  import scp_pkg::*;

  logic    valid_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ src/serial_set_command_parser.sv @@
// ----------------------------------------------------------------------------
// serial_set_command_parser
// Frames serial bytes into "action;type;serial;variable;value" commands.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle; a byte that does not close a frame is
// taken even while a result waits in the output register; a closing byte then
// stalls until it is read; a result shows in the cycle after the closing beat.
// Reset clears the frame state and empties the output register.
module serial_set_command_parser #(
  parameter int unsigned MaxLen = scp_pkg::MaxLenDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rx_valid_i,
  output logic                       rx_ready_o,
  input  logic [scp_pkg::ByteW-1:0]  rx_byte_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic                       command_valid_o,
  output logic [scp_pkg::ValW-1:0]   module_type_o,
  output logic [scp_pkg::ValW-1:0]   module_serial_o,
  output logic [scp_pkg::ValW-1:0]   variable_index_o,
  output logic [scp_pkg::ValW-1:0]   new_value_o
);
  import scp_pkg::*;

  logic    beat;
  logic    close;
  frame_t  close_state;
  result_t res_c, res_q;

  // Only a closing byte needs the output slot.
  assign rx_ready_o = !close || !res_valid_o || res_ready_i;
  assign beat       = rx_valid_i && rx_ready_o;

  scp_frame #(
    .MaxLen(MaxLen)
  ) u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .byte_i       (rx_byte_i),
    .close_o      (close),
    .close_state_o(close_state)
  );

  scp_check u_check (
    .frame_i(close_state),
    .res_o  (res_c)
  );

  scp_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (beat && close),
    .res_i  (res_c),
    .ready_i(res_ready_i),
    .valid_o(res_valid_o),
    .res_o  (res_q)
  );

  assign command_valid_o  = res_q.ok;
  assign module_type_o    = res_q.val[0];
  assign module_serial_o  = res_q.val[1];
  assign variable_index_o = res_q.val[2];
  assign new_value_o      = res_q.val[3];

endmodule

@@ tb/scp_command_checker.sv @@
// ----------------------------------------------------------------------------
// scp_command_checker
// Watches both channels of the set-command parser, predicts every command
// result from the accepted byte beats and compares each result beat, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
module scp_command_checker #(
  parameter int unsigned MaxLen = scp_pkg::MaxLenDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rx_valid_i,
  input  logic                       rx_ready_i,
  input  logic [scp_pkg::ByteW-1:0]  rx_byte_i,
  input  logic                       res_valid_i,
  input  logic                       res_ready_i,
  input  logic                       command_valid_i,
  input  logic [scp_pkg::ValW-1:0]   module_type_i,
  input  logic [scp_pkg::ValW-1:0]   module_serial_i,
  input  logic [scp_pkg::ValW-1:0]   variable_index_i,
  input  logic [scp_pkg::ValW-1:0]   new_value_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);
  import scp_pkg::*;

  typedef struct packed {
    logic            ok;
    logic [ValW-1:0] mtype;
    logic [ValW-1:0] serial;
    logic [ValW-1:0] index;
    logic [ValW-1:0] value;
  } command_t;

  command_t cmd_expected_q[$];

  // Shadow copy of the frame being parsed.
  logic [CountW-1:0] frm_bytes  = '0;
  logic [CountW-1:0] frm_fields = '0;
  logic [ByteW-1:0]  frm_action = '0;
  logic [AccW-1:0]   frm_acc [NumField] = '{default: '0};
  logic              frm_nul    = 1'b0;

  int unsigned fail_cnt    = 0;
  int unsigned pending_cnt = 0;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pending_cnt;

  function automatic string show(command_t c);
    return $sformatf("valid=%0d type=%0d serial=%0d index=%0d value=%0d",
                     c.ok, c.mtype, c.serial, c.index, c.value);
  endfunction

  task automatic close_frame();
    command_t c;
    logic     ok;
    ok = (frm_action == CharA) && (frm_fields == FieldLast);
    // A negative signed value reads as at least 0x8000, so one unsigned
    // compare covers both ends of the range.
    for (int k = 0; k < NumField; k++) begin
      if (frm_acc[k] > ValLimit) ok = 1'b0;
    end
    c.ok     = ok;
    c.mtype  = ok ? frm_acc[0][ValW-1:0] : '0;
    c.serial = ok ? frm_acc[1][ValW-1:0] : '0;
    c.index  = ok ? frm_acc[2][ValW-1:0] : '0;
    c.value  = ok ? frm_acc[3][ValW-1:0] : '0;
    cmd_expected_q.push_back(c);
    pending_cnt++;
    frm_bytes  = '0;
    frm_fields = '0;
    frm_action = '0;
    frm_nul    = 1'b0;
    for (int k = 0; k < NumField; k++) frm_acc[k] = '0;
  endtask

  task automatic fold_byte(input logic [ByteW-1:0] b);
    logic [AccW-1:0]   digit;
    logic [CountW-1:0] fm1;
    logic [1:0]        slot;
    digit = {{(AccW-ByteW){b[ByteW-1]}}, b};
    fm1   = frm_fields - 5'd1;
    slot  = fm1[1:0];
    if (b == CharBar) begin
      close_frame();
    end else begin
      if (!frm_nul) begin
        if (b == CharNul) begin
          frm_nul = 1'b1;
        end else if (b == CharSemi) begin
          if (frm_fields < FieldSat) frm_fields = frm_fields + 1'b1;
        end else if (frm_fields == '0) begin
          frm_action = b;
        end else if (frm_fields <= FieldLast) begin
          frm_acc[slot] = frm_acc[slot] * 16'd10 + digit - DigitBase;
        end
      end
      // Bytes after a NUL still fill the frame.
      frm_bytes = frm_bytes + 1'b1;
      if (frm_bytes >= MaxLen) close_frame();
    end
  endtask

  always @(posedge clk_i) begin
    command_t got;
    command_t want;
    if (rst_ni) begin
      // The result of a closing beat is registered and shows up in the cycle after
      // it, so popping before folding the current byte beat is safe.
      if (res_valid_i && res_ready_i) begin
        got.ok     = command_valid_i;
        got.mtype  = module_type_i;
        got.serial = module_serial_i;
        got.index  = variable_index_i;
        got.value  = new_value_i;
        if (cmd_expected_q.size() == 0) begin
          if (fail_cnt < 10) $display("unexpected command result: %s", show(got));
          fail_cnt++;
        end else begin
          want = cmd_expected_q.pop_front();
          pending_cnt--;
          if (got !== want) begin
            if (fail_cnt < 10) begin
              $display("command mismatch: expected %s", show(want));
              $display("                  actual   %s", show(got));
            end
            fail_cnt++;
          end
        end
      end
      if (rx_valid_i && rx_ready_i) fold_byte(rx_byte_i);
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives byte beats into the set-command parser: a few directed frames, then
// random well-formed, corrupted, noisy, overlong and empty frames under three
// idling patterns and one long receiver hold-off. The checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import scp_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             rx_valid;
  logic             rx_ready;
  logic [ByteW-1:0] rx_byte;
  logic             res_valid;
  logic             res_ready;
  logic             command_valid;
  logic [ValW-1:0]  module_type;
  logic [ValW-1:0]  module_serial;
  logic [ValW-1:0]  variable_index;
  logic [ValW-1:0]  new_value;

  int unsigned fail_count;
  int unsigned pending;

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned hold_left    = 0;
  int unsigned beats_sent   = 0;

  logic [ByteW-1:0] frame_q[$];

  always #6 clk = ~clk;

  serial_set_command_parser u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .rx_valid_i       (rx_valid),
    .rx_ready_o       (rx_ready),
    .rx_byte_i        (rx_byte),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .command_valid_o  (command_valid),
    .module_type_o    (module_type),
    .module_serial_o  (module_serial),
    .variable_index_o (variable_index),
    .new_value_o      (new_value)
  );

  scp_command_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .rx_valid_i       (rx_valid),
    .rx_ready_i       (rx_ready),
    .rx_byte_i        (rx_byte),
    .res_valid_i      (res_valid),
    .res_ready_i      (res_ready),
    .command_valid_i  (command_valid),
    .module_type_i    (module_type),
    .module_serial_i  (module_serial),
    .variable_index_i (variable_index),
    .new_value_i      (new_value),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < snd_idle_pct) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i]);
  endtask

  task automatic send_frame_q();
    foreach (frame_q[i]) send_beat(frame_q[i]);
  endtask

  function automatic int unsigned pick_value();
    int unsigned v;
    case ($urandom_range(9))
      7: begin
        case ($urandom_range(3))
          0:       v = 0;
          1:       v = 1023;
          2:       v = 1024;
          default: v = 1025;
        endcase
      end
      8, 9:    v = $urandom_range(99999, 1025);
      default: v = $urandom_range(1024);
    endcase
    return v;
  endfunction

  function automatic logic [ByteW-1:0] noise_byte();
    logic [ByteW-1:0] b;
    case ($urandom_range(7))
      0, 1, 2: b = DigitBase[ByteW-1:0] + 8'($urandom_range(9));
      3:       b = CharSemi;
      4:       b = CharNul;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  task automatic push_number(input int unsigned v);
    int unsigned digits[$];
    if ($urandom_range(9) == 0) frame_q.push_back(DigitBase[ByteW-1:0]);
    do begin
      digits.push_front(v % 10);
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) frame_q.push_back(DigitBase[ByteW-1:0] + 8'(digits[i]));
  endtask

  task automatic build_frame();
    int unsigned kind;
    int unsigned nsep;
    int unsigned len;
    int unsigned pos;
    frame_q.delete();
    kind = $urandom_range(99);
    if (kind < 70) begin
      // Command shaped frame; from 55 up one byte is overwritten with junk.
      frame_q.push_back(($urandom_range(9) != 0) ? CharA : 8'($urandom_range(255)));
      nsep = ($urandom_range(9) != 0) ? 4 : $urandom_range(6);
      for (int f = 0; f < nsep; f++) begin
        frame_q.push_back(CharSemi);
        push_number(pick_value());
      end
      if (kind >= 55) begin
        pos = $urandom_range(frame_q.size() - 1);
        frame_q[pos] = ($urandom_range(3) == 0) ? CharNul : 8'($urandom_range(255));
      end
      if ($urandom_range(19) != 0) frame_q.push_back(CharBar);
    end else if (kind < 85) begin
      len = $urandom_range(30);
      repeat (len) frame_q.push_back(noise_byte());
      if ($urandom_range(1) != 0) frame_q.push_back(CharBar);
    end else if (kind < 95) begin
      // No terminator: the frame closes when it is full.
      len = $urandom_range(MaxLenDefault + 6, MaxLenDefault - 1);
      frame_q.push_back(CharA);
      repeat (len - 1) begin
        frame_q.push_back(($urandom_range(3) == 0) ? CharSemi
                          : DigitBase[ByteW-1:0] + 8'($urandom_range(9)));
      end
    end else begin
      frame_q.push_back(CharBar);
    end
  endtask

  task automatic run_frames(input int unsigned n);
    int unsigned target;
    target = beats_sent + n;
    while (beats_sent < target) begin
      build_frame();
      send_frame_q();
    end
  endtask

  // Receiver side of the result channel.
  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        res_ready <= 1'b0;
        hold_left--;
      end else begin
        res_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    rst_n    = 1'b0;
    rx_valid = 1'b0;
    rx_byte  = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty frame, a valid command at the range limits, a frame with a
    // signed byte and a NUL, and a negative field.
    send_text("|");
    send_text("a;1024;0;0;1024|");
    send_beat(8'hFF);
    send_beat(CharNul);
    send_beat(8'h80);
    send_beat(CharBar);
    send_text("a;-1;2;3;4|");

    snd_idle_pct = 18;
    rcv_idle_pct = 55;
    run_frames(480);
    snd_idle_pct = 55;
    rcv_idle_pct = 18;
    run_frames(480);
    // Full-rate sender against a stalled receiver fills the output register.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_left    = 300;
    run_frames(490);

    rx_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
